[rtl/pts_pkg.sv]
// Shared types, codes and helpers for the process table scheduler.
package pts_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   localparam int MODE_W   = 3;
   localparam int PID_W    = 15;
   localparam int PRIO_W   = 8;
   localparam int EXIT_W   = 8;
   localparam int SKIP_W   = 8;
   localparam int QUEUE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [SKIP_W-1:0] SKIP_LIMIT_RESET = 8'd4;
   localparam logic [SKIP_W-1:0] SKIP_MAX         = '1;

   localparam logic [MODE_W-1:0] MODE_ADMIT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUSPEND   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESUME    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TERMINATE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RETIRE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SELECT    = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   localparam logic [QUEUE_W-1:0] Q_READY = 2'd0;
   localparam logic [QUEUE_W-1:0] Q_SUSP  = 2'd1;
   localparam logic [QUEUE_W-1:0] Q_TERM  = 2'd2;

   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef struct packed {
      logic [EXIT_W-1:0]  exit_status;
      logic [SKIP_W-1:0]  skips;
      logic [QUEUE_W-1:0] queue;
      logic               critical;
      logic [PRIO_W-1:0]  prio;
      logic [PID_W-1:0]   pid;
   } slot_entry_type;

   typedef struct packed {
      logic           found;
      slot_idx_type   idx;
      slot_entry_type ent;
   } cand_type;

   typedef struct packed {
      logic         free_found;
      slot_idx_type free_idx;
      cand_type     rdy;
      cand_type     sus;
      cand_type     crit;
      cand_type     starv;
      cand_type     best;
   } scan_type;

   function automatic logic [COUNT_W-1:0] sat_count(input count_type c);
      int unsigned v;
      v = 32'(c);
      return (v > 32'd31) ? 5'd31 : v[COUNT_W-1:0];
   endfunction

endpackage

[rtl/pts_slot_ram.sv]
// Slot table storage: one write port and one registered read port.
module pts_slot_ram import pts_pkg::*; (
   input  logic           clock,
   input  logic           wr_en,
   input  slot_idx_type   wr_addr,
   input  slot_entry_type wr_data,
   input  slot_idx_type   rd_addr,
   output slot_entry_type rd_data
);

   slot_entry_type mem_ff [NUM_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pts_compare.sv]
// Per-slot compare unit: folds one slot into the running scan results.
module pts_compare import pts_pkg::*; (
   input  logic              slot_used,
   input  slot_idx_type      slot_idx,
   input  slot_entry_type    slot_ent,
   input  logic [PID_W-1:0]  cmd_pid,
   input  logic [SKIP_W-1:0] skip_limit,
   input  scan_type          scan_cur,
   output scan_type          scan_nxt
);

   logic in_ready;
   logic in_susp;
   logic pid_hit;

   assign in_ready = slot_used && (slot_ent.queue == Q_READY);
   assign in_susp  = slot_used && (slot_ent.queue == Q_SUSP);
   assign pid_hit  = (slot_ent.pid == cmd_pid);

   always_comb begin
      scan_nxt = scan_cur;
      if (!slot_used && !scan_cur.free_found) begin
         scan_nxt.free_found = 1'b1;
         scan_nxt.free_idx   = slot_idx;
      end
      if (in_ready && pid_hit && !scan_cur.rdy.found) begin
         scan_nxt.rdy.found = 1'b1;
         scan_nxt.rdy.idx   = slot_idx;
         scan_nxt.rdy.ent   = slot_ent;
      end
      if (in_susp && pid_hit && !scan_cur.sus.found) begin
         scan_nxt.sus.found = 1'b1;
         scan_nxt.sus.idx   = slot_idx;
         scan_nxt.sus.ent   = slot_ent;
      end
      if (in_ready && slot_ent.critical &&
          (!scan_cur.crit.found || slot_ent.pid < scan_cur.crit.ent.pid)) begin
         scan_nxt.crit.found = 1'b1;
         scan_nxt.crit.idx   = slot_idx;
         scan_nxt.crit.ent   = slot_ent;
      end
      if (in_ready && (slot_ent.skips >= skip_limit) &&
          (!scan_cur.starv.found || slot_ent.pid < scan_cur.starv.ent.pid)) begin
         scan_nxt.starv.found = 1'b1;
         scan_nxt.starv.idx   = slot_idx;
         scan_nxt.starv.ent   = slot_ent;
      end
      if (in_ready && (!scan_cur.best.found ||
                       slot_ent.prio < scan_cur.best.ent.prio ||
                       (slot_ent.prio == scan_cur.best.ent.prio &&
                        slot_ent.pid < scan_cur.best.ent.pid))) begin
         scan_nxt.best.found = 1'b1;
         scan_nxt.best.idx   = slot_idx;
         scan_nxt.best.ent   = slot_ent;
      end
   end

endmodule

[rtl/process_table_scheduler.sv]
// Process table scheduler: slot sweep sequencer, queue counts and result register.
// Flow: an accepted command starts a sweep of every slot, one slot per cycle through the
//   single read port, then an update step; a successful select adds an aging sweep
//   before the result is registered. A new command is taken only in idle, once the
//   previous result has moved to the response register, which waits for rsp_tready.
// Reset: synchronous; clears slot valid bits, counts, result valid; skip limit to 4.
module process_table_scheduler import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: pid[14:0], priority_req[22:15], critical[23], exit_status[31:24]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: mode[2:0]
   input  logic [2:0]  req_tuser,
   // rsp_tdata: out_pid[14:0], out_priority[22:15], out_critical[23],
   //   out_exit_status[31:24], ready_count[36:32], suspended_count[41:37],
   //   terminated_count[46:42], zero[47]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]  rsp_tuser,
   // csr_data: skip_limit[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_AGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    pid;
      logic [PRIO_W-1:0]   prio;
      logic                critical;
      logic [EXIT_W-1:0]   exit_status;
      logic [COUNT_W-1:0]  ready_count;
      logic [COUNT_W-1:0]  susp_count;
      logic [COUNT_W-1:0]  term_count;
   } result_type;

   state_type              state_ff, state_in;
   logic [SKIP_W-1:0]      skip_limit_ff, skip_limit_in;
   logic [NUM_SLOTS-1:0]   used_ff, used_in;
   slot_idx_type           idx_ff, idx_in;
   count_type              rc_ff, rc_in;
   count_type              sc_ff, sc_in;
   count_type              tc_ff, tc_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [PID_W-1:0]       pid_ff, pid_in;
   logic [PRIO_W-1:0]      prio_ff, prio_in;
   logic                   crit_ff, crit_in;
   logic [EXIT_W-1:0]      exit_ff, exit_in;
   scan_type               scan_ff, scan_in;
   result_type             res_ff, res_in;
   result_type             rsp_ff, rsp_in;

   scan_type               scan_nxt;
   cand_type               sel;
   logic                   last_slot;
   logic                   ram_wr_en;
   slot_idx_type           ram_wr_addr;
   slot_entry_type         ram_wr_data;
   slot_idx_type           ram_rd_addr;
   slot_entry_type         ram_rd_data;

   pts_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pts_compare u_compare (
      .slot_used  (used_ff[idx_ff]),
      .slot_idx   (idx_ff),
      .slot_ent   (ram_rd_data),
      .cmd_pid    (pid_ff),
      .skip_limit (skip_limit_ff),
      .scan_cur   (scan_ff),
      .scan_nxt   (scan_nxt)
   );

   assign last_slot   = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
   assign ram_rd_addr = (state_ff == ST_SCAN || state_ff == ST_AGE) ?
                        idx_ff + SLOT_W'(1) : '0;
   assign sel = scan_ff.crit.found  ? scan_ff.crit  :
                scan_ff.starv.found ? scan_ff.starv : scan_ff.best;

   always_comb begin
      state_in      = state_ff;
      skip_limit_in = csr_valid ? csr_data : skip_limit_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      rc_in         = rc_ff;
      sc_in         = sc_ff;
      tc_in         = tc_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      pid_in        = pid_ff;
      prio_in       = prio_ff;
      crit_in       = crit_ff;
      exit_in       = exit_ff;
      scan_in       = scan_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = ram_rd_data;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               pid_in   = req_tdata[14:0];
               prio_in  = req_tdata[22:15];
               crit_in  = req_tdata[23];
               exit_in  = req_tdata[31:24];
               idx_in   = '0;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_nxt;
            idx_in  = idx_ff + SLOT_W'(1);
            if (last_slot) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            res_in   = '0;
            state_in = ST_DONE;
            unique case (mode_ff) inside
               MODE_ADMIT, MODE_RETIRE: begin
                  if (!scan_ff.free_found) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     ram_wr_en                 = 1'b1;
                     ram_wr_addr               = scan_ff.free_idx;
                     ram_wr_data.pid           = pid_ff;
                     ram_wr_data.prio          = prio_ff;
                     ram_wr_data.critical      = crit_ff;
                     ram_wr_data.skips         = '0;
                     used_in[scan_ff.free_idx] = 1'b1;
                     if (mode_ff == MODE_ADMIT) begin
                        ram_wr_data.queue       = Q_READY;
                        ram_wr_data.exit_status = '0;
                        rc_in                   = rc_ff + CNT_W'(1);
                     end else begin
                        ram_wr_data.queue       = Q_TERM;
                        ram_wr_data.exit_status = exit_ff;
                        res_in.exit_status      = exit_ff;
                        tc_in                   = tc_ff + CNT_W'(1);
                     end
                  end
               end
               MODE_SUSPEND: begin
                  if (!scan_ff.rdy.found) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_addr       = scan_ff.rdy.idx;
                     ram_wr_data       = scan_ff.rdy.ent;
                     ram_wr_data.queue = Q_SUSP;
                     rc_in             = rc_ff - CNT_W'(1);
                     sc_in             = sc_ff + CNT_W'(1);
                  end
               end
               MODE_RESUME: begin
                  if (!scan_ff.sus.found) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_addr       = scan_ff.sus.idx;
                     ram_wr_data       = scan_ff.sus.ent;
                     ram_wr_data.queue = Q_READY;
                     sc_in             = sc_ff - CNT_W'(1);
                     rc_in             = rc_ff + CNT_W'(1);
                  end
               end
               MODE_TERMINATE: begin
                  if (scan_ff.rdy.found) begin
                     ram_wr_en               = 1'b1;
                     ram_wr_addr             = scan_ff.rdy.idx;
                     ram_wr_data             = scan_ff.rdy.ent;
                     ram_wr_data.queue       = Q_TERM;
                     ram_wr_data.exit_status = exit_ff;
                     res_in.exit_status      = exit_ff;
                     rc_in                   = rc_ff - CNT_W'(1);
                     tc_in                   = tc_ff + CNT_W'(1);
                  end else if (scan_ff.sus.found) begin
                     ram_wr_en               = 1'b1;
                     ram_wr_addr             = scan_ff.sus.idx;
                     ram_wr_data             = scan_ff.sus.ent;
                     ram_wr_data.queue       = Q_TERM;
                     ram_wr_data.exit_status = exit_ff;
                     res_in.exit_status      = exit_ff;
                     sc_in                   = sc_ff - CNT_W'(1);
                     tc_in                   = tc_ff + CNT_W'(1);
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               MODE_SELECT: begin
                  if (!sel.found) begin
                     res_in.status = STATUS_EMPTY;
                  end else begin
                     used_in[sel.idx] = 1'b0;
                     rc_in            = rc_ff - CNT_W'(1);
                     res_in.pid       = sel.ent.pid;
                     res_in.prio      = sel.ent.prio;
                     res_in.critical  = sel.ent.critical;
                     idx_in           = '0;
                     state_in         = ST_AGE;
                  end
               end
               default: begin
               end
            endcase
            res_in.ready_count = sat_count(rc_in);
            res_in.susp_count  = sat_count(sc_in);
            res_in.term_count  = sat_count(tc_in);
         end
         ST_AGE: begin
            if (used_ff[idx_ff] && ram_rd_data.queue == Q_READY &&
                ram_rd_data.skips != SKIP_MAX) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = idx_ff;
               ram_wr_data.skips = ram_rd_data.skips + SKIP_W'(1);
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (last_slot) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         skip_limit_ff <= SKIP_LIMIT_RESET;
         used_ff       <= '0;
         idx_ff        <= '0;
         rc_ff         <= '0;
         sc_ff         <= '0;
         tc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         skip_limit_ff <= skip_limit_in;
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         rc_ff         <= rc_in;
         sc_ff         <= sc_in;
         tc_ff         <= tc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      pid_ff  <= pid_in;
      prio_ff <= prio_in;
      crit_ff <= crit_in;
      exit_ff <= exit_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {1'b0, rsp_ff.term_count, rsp_ff.susp_count, rsp_ff.ready_count,
                        rsp_ff.exit_status, rsp_ff.critical, rsp_ff.prio, rsp_ff.pid};

endmodule

[rtl/pts_checker.sv]
// Port-level checker for the process table scheduler, bound to the top level.
module pts_checker import pts_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [7:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while previous command in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[36:32]) + 32'(rsp_tdata[41:37]) +
                      32'(rsp_tdata[46:42])) <= 32'(NUM_SLOTS))
      else $error("queue counts exceed table size");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("failed command returned nonzero process fields");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata[36:32] == 5'd0)
      else $error("empty select with nonzero ready count");

endmodule

bind process_table_scheduler pts_checker u_checker (.*);

[test/process_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the process table scheduler: mirrors the slot table and compares every response.
module process_table_checker import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          pending_count,
   output int          response_count
);

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    pid;
      logic [PRIO_W-1:0]   prio;
      logic                crit;
      logic [EXIT_W-1:0]   exit_status;
      logic [COUNT_W-1:0]  ready_n;
      logic [COUNT_W-1:0]  susp_n;
      logic [COUNT_W-1:0]  term_n;
   } reply_type;

   typedef enum int {PICK_CRITICAL, PICK_STARVING, PICK_PRIORITY} pick_rule_type;

   bit                 tab_used  [NUM_SLOTS];
   logic [PID_W-1:0]   tab_pid   [NUM_SLOTS];
   logic [PRIO_W-1:0]  tab_prio  [NUM_SLOTS];
   logic               tab_crit  [NUM_SLOTS];
   logic [QUEUE_W-1:0] tab_queue [NUM_SLOTS];
   logic [SKIP_W-1:0]  tab_skips [NUM_SLOTS];
   logic [EXIT_W-1:0]  tab_exit  [NUM_SLOTS];
   logic [SKIP_W-1:0]  skip_limit = SKIP_LIMIT_RESET;

   reply_type expected_replies[$];
   int        mismatches = 0;
   int        replies = 0;

   function automatic int find_slot(input logic [PID_W-1:0] pid, input logic [QUEUE_W-1:0] q);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (tab_used[i] && tab_queue[i] == q && tab_pid[i] == pid) return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < NUM_SLOTS; i++)
         if (!tab_used[i]) return i;
      return -1;
   endfunction

   function automatic logic [COUNT_W-1:0] queue_size(input logic [QUEUE_W-1:0] q);
      int n = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (tab_used[i] && tab_queue[i] == q) n++;
      return (n > 31) ? COUNT_W'(31) : COUNT_W'(n);
   endfunction

   function automatic int choose_slot(input pick_rule_type rule);
      int best = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!tab_used[i] || tab_queue[i] != Q_READY) continue;
         if (rule == PICK_CRITICAL && !tab_crit[i]) continue;
         if (rule == PICK_STARVING && tab_skips[i] < skip_limit) continue;
         if (best < 0) begin
            best = i;
         end else if (rule == PICK_PRIORITY && tab_prio[i] != tab_prio[best]) begin
            if (tab_prio[i] < tab_prio[best]) best = i;
         end else if (tab_pid[i] < tab_pid[best]) begin
            best = i;
         end
      end
      return best;
   endfunction

   function automatic reply_type predict_command(input logic [2:0] mode, input logic [31:0] data);
      reply_type          r;
      logic [PID_W-1:0]   pid;
      logic [PRIO_W-1:0]  prio;
      logic               crit;
      logic [EXIT_W-1:0]  ex;
      int                 s;
      r = '0;
      r.status = STATUS_OK;
      pid  = data[14:0];
      prio = data[22:15];
      crit = data[23];
      ex   = data[31:24];
      case (mode)
         MODE_ADMIT, MODE_RETIRE: begin
            s = free_slot();
            if (s < 0) begin
               r.status = STATUS_FULL;
            end else begin
               tab_used[s]  = 1'b1;
               tab_pid[s]   = pid;
               tab_prio[s]  = prio;
               tab_crit[s]  = crit;
               tab_skips[s] = '0;
               tab_queue[s] = (mode == MODE_ADMIT) ? Q_READY : Q_TERM;
               tab_exit[s]  = (mode == MODE_ADMIT) ? '0 : ex;
               if (mode == MODE_RETIRE) r.exit_status = ex;
            end
         end
         MODE_SUSPEND: begin
            s = find_slot(pid, Q_READY);
            if (s < 0) r.status = STATUS_NOT_FOUND;
            else tab_queue[s] = Q_SUSP;
         end
         MODE_RESUME: begin
            s = find_slot(pid, Q_SUSP);
            if (s < 0) r.status = STATUS_NOT_FOUND;
            else tab_queue[s] = Q_READY;
         end
         MODE_TERMINATE: begin
            s = find_slot(pid, Q_READY);
            if (s < 0) s = find_slot(pid, Q_SUSP);
            if (s < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               tab_queue[s]  = Q_TERM;
               tab_exit[s]   = ex;
               r.exit_status = ex;
            end
         end
         MODE_SELECT: begin
            s = choose_slot(PICK_CRITICAL);
            if (s < 0) s = choose_slot(PICK_STARVING);
            if (s < 0) s = choose_slot(PICK_PRIORITY);
            if (s < 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.pid  = tab_pid[s];
               r.prio = tab_prio[s];
               r.crit = tab_crit[s];
               tab_skips[s] = '0;
               tab_used[s]  = 1'b0;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (tab_used[i] && tab_queue[i] == Q_READY && tab_skips[i] != SKIP_MAX)
                     tab_skips[i]++;
            end
         end
         default: ;
      endcase
      r.ready_n = queue_size(Q_READY);
      r.susp_n  = queue_size(Q_SUSP);
      r.term_n  = queue_size(Q_TERM);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] response %0d: %s is 0x%0h, expected 0x%0h",
                  $time, replies, field, got, want);
      mismatches++;
   endtask

   task automatic check_reply(input logic [1:0] status_bits, input logic [47:0] data);
      reply_type got;
      reply_type want;
      got.status      = status_bits;
      got.pid         = data[14:0];
      got.prio        = data[22:15];
      got.crit        = data[23];
      got.exit_status = data[31:24];
      got.ready_n     = data[36:32];
      got.susp_n      = data[41:37];
      got.term_n      = data[46:42];
      if (data[47] !== 1'b0) report_mismatch("pad bit", 32'(data[47]), 32'd0);
      if (expected_replies.size() == 0) begin
         report_mismatch("response with no command pending", 32'(got.status), 32'd0);
         return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.pid !== want.pid) report_mismatch("out_pid", 32'(got.pid), 32'(want.pid));
      if (got.prio !== want.prio)
         report_mismatch("out_priority", 32'(got.prio), 32'(want.prio));
      if (got.crit !== want.crit)
         report_mismatch("out_critical", 32'(got.crit), 32'(want.crit));
      if (got.exit_status !== want.exit_status)
         report_mismatch("out exit status", 32'(got.exit_status), 32'(want.exit_status));
      if (got.ready_n !== want.ready_n)
         report_mismatch("ready_count", 32'(got.ready_n), 32'(want.ready_n));
      if (got.susp_n !== want.susp_n)
         report_mismatch("suspended_count", 32'(got.susp_n), 32'(want.susp_n));
      if (got.term_n !== want.term_n)
         report_mismatch("terminated_count", 32'(got.term_n), 32'(want.term_n));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tab_used = '{default: 1'b0};
         skip_limit = SKIP_LIMIT_RESET;
         expected_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies++;
            check_reply(rsp_tuser, rsp_tdata);
         end
         if (csr_valid && csr_ready) skip_limit = csr_data;
         if (req_tvalid && req_tready)
            expected_replies.push_back(predict_command(req_tuser, req_tdata));
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_replies.size();
      response_count <= replies;
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the process table scheduler testbench: clock, reset, command stimulus and verdict.
module testbench;
   import pts_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 100;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 40;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int mismatch_count;
   int pending_count;
   int response_count;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int commands_sent = 0;
   int cycle_count = 0;
   int term_budget = 0;

   process_table_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   process_table_checker table_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .response_count (response_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count, pending_count);
         $display("process_table_scheduler verification failed");
         $finish;
      end
   end

   task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [PID_W-1:0] pid,
                           input logic [PRIO_W-1:0] prio, input logic crit,
                           input logic [EXIT_W-1:0] ex);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {ex, crit, prio, pid};
      do @(posedge clock); while (req_tready !== 1'b1);
      commands_sent++;
   endtask

   function automatic logic [PID_W-1:0] draw_pid();
      int r = $urandom_range(99);
      if (r < 70) return PID_W'($urandom_range(7));
      if (r < 80) return PID_W'(32767 - $urandom_range(3));
      return PID_W'($urandom_range(32767));
   endfunction

   task automatic send_random(input logic [MODE_W-1:0] mode);
      logic [PRIO_W-1:0] prio;
      prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
      send_cmd(mode, draw_pid(), prio, $urandom_range(99) < 15, EXIT_W'($urandom));
   endtask

   // hold the sender until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_skip_limit(input logic [SKIP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   task automatic run_sequence();
      int               kind;
      logic [PID_W-1:0] pid;
      kind = $urandom_range(99);
      if (kind < 30) begin
         repeat ($urandom_range(1, 8)) send_random(MODE_ADMIT);
      end else if (kind < 52) begin
         repeat ($urandom_range(1, 6)) send_random(MODE_SELECT);
      end else if (kind < 66) begin
         pid = draw_pid();
         send_cmd(MODE_SUSPEND, pid, PRIO_W'($urandom), 1'b0, EXIT_W'($urandom));
         repeat ($urandom_range(0, 3)) send_random(MODE_SELECT);
         send_cmd(MODE_RESUME, pid, PRIO_W'($urandom), 1'b1, EXIT_W'($urandom));
      end else if (kind < 76) begin
         send_random(MODE_RESUME);
      end else if (kind < 86) begin
         send_random(MODE_SUSPEND);
      end else if (kind < 94) begin
         // terminated slots are never freed, so spend them sparingly
         if (term_budget > 0 && $urandom_range(3) == 0) begin
            term_budget--;
            send_random($urandom_range(1) ? MODE_TERMINATE : MODE_RETIRE);
         end else begin
            send_cmd(MODE_TERMINATE, PID_W'($urandom_range(16384, 32763)),
                     PRIO_W'($urandom), 1'($urandom_range(1)), EXIT_W'($urandom));
         end
      end else begin
         send_random($urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI);
      end
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(MODE_SELECT, 15'd0, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_RESUME, 15'd9, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_SPARE_LO, 15'd1, 8'd1, 1'b1, 8'd1);
      send_cmd(MODE_SPARE_HI, 15'd32767, 8'd255, 1'b1, 8'd255);
      send_cmd(MODE_RETIRE, 15'd32767, 8'd255, 1'b1, 8'd255);
      send_cmd(MODE_ADMIT, 15'd0, 8'd255, 1'b0, 8'd0);
      send_cmd(MODE_ADMIT, 15'd32767, 8'd0, 1'b0, 8'd255);
      send_cmd(MODE_ADMIT, 15'd3, 8'd7, 1'b0, 8'd0);
      send_cmd(MODE_ADMIT, 15'd3, 8'd2, 1'b0, 8'd0);
      send_cmd(MODE_ADMIT, 15'd9, 8'd7, 1'b1, 8'd0);
      send_cmd(MODE_SUSPEND, 15'd3, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_TERMINATE, 15'd5, 8'd0, 1'b0, 8'd17);
      send_cmd(MODE_SELECT, 15'd0, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_SELECT, 15'd0, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_RESUME, 15'd3, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_SUSPEND, 15'd0, 8'd0, 1'b0, 8'd0);
      send_cmd(MODE_TERMINATE, 15'd0, 8'd0, 1'b0, 8'd0);
      repeat (3) send_cmd(MODE_SELECT, 15'd0, 8'd0, 1'b0, 8'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_gap_pct = 47; rsp_stall_pct <= 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct <= 47; end
            default: begin send_gap_pct = 28; rsp_stall_pct <= 28; end
         endcase
         case (phase)
            0: ;
            1, 5: write_skip_limit(8'd1);
            2, 6: write_skip_limit(8'd255);
            3: write_skip_limit(8'd2);
            default: write_skip_limit(SKIP_W'($urandom_range(1, 255)));
         endcase
         term_budget++;
         target = commands_sent + PHASE_ITEMS / 2;
         while (commands_sent < target) run_sequence();
         drain();
         target = commands_sent + PHASE_ITEMS / 2;
         while (commands_sent < target) run_sequence();
      end

      // fill the rest of the table with terminated processes
      repeat (18) send_random(MODE_RETIRE);
      send_random(MODE_ADMIT);
      repeat (2) send_random(MODE_SELECT);
      send_random(MODE_TERMINATE);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d commands over %0d phases: starvation limits 4, 1, 255, 2 and random,",
               commands_sent, PHASES);
      $display("idle and stall patterns on both channels; %0d responses checked",
               response_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("process_table_scheduler verification clean");
      else
         $display("process_table_scheduler verification failed");
      $finish;
   end

endmodule
